// ===== rtl/core/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, codes and item types of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int RADIUS_WIDTH = 12;
  localparam int OFFSET_WIDTH = RADIUS_WIDTH + 1;   // octant offsets, signed
  localparam int DIAM_WIDTH   = RADIUS_WIDTH + 1;   // 2r, unsigned
  localparam int STEP_WIDTH   = RADIUS_WIDTH + 2;   // tx / ty increments
  localparam int ERR_WIDTH    = RADIUS_WIDTH + 3;   // decision error, signed
  localparam int CALC_WIDTH   = ERR_WIDTH + 2;      // headroom for the update
  localparam int POINTS_PER_STEP = 8;
  localparam int POINT_IDX_WIDTH = $clog2(POINTS_PER_STEP);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = COORD_WIDTH;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_X = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Y = 1'b1;

  typedef struct packed {
    logic                           op;
    logic signed [COORD_WIDTH-1:0]  center_x;
    logic signed [COORD_WIDTH-1:0]  center_y;
    logic [RADIUS_WIDTH-1:0]        radius;
  } item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          step_last;
    logic                          circle_done;
  } result_t;

  // One octant step handed from the stepper to the point emitter.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0]  cx;
    logic signed [COORD_WIDTH-1:0]  cy;
    logic signed [OFFSET_WIDTH-1:0] x_off;
    logic signed [OFFSET_WIDTH-1:0] y_off;
    logic                           done;
  } step_rec_t;

endpackage

// ===== rtl/core/mcr_front.sv =====
// ----------------------------------------------------------------------------
// mcr_front
// Accepts items, holds the screen offsets and the octant stepper, and pushes
// one step record per tick of a running circle.
// ----------------------------------------------------------------------------
module mcr_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mcr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [mcr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  logic                                  push,
  input  mcr_pkg::item_t                        item,
  output logic                                  full,
  output logic                                  rec_push,
  output mcr_pkg::step_rec_t                    rec,
  input  logic                                  rec_full
);

  localparam int CW = mcr_pkg::COORD_WIDTH;
  localparam int OW = mcr_pkg::OFFSET_WIDTH;
  localparam int DW = mcr_pkg::DIAM_WIDTH;
  localparam int SW = mcr_pkg::STEP_WIDTH;
  localparam int EW = mcr_pkg::ERR_WIDTH;
  localparam int KW = mcr_pkg::CALC_WIDTH;

  logic signed [CW-1:0] screen_offset_x;
  logic signed [CW-1:0] screen_offset_y;
  logic signed [CW-1:0] screen_cx;
  logic signed [CW-1:0] screen_cy;
  logic signed [OW-1:0] x_offset;
  logic signed [OW-1:0] y_offset;
  logic [SW-1:0]        step_tx;
  logic [SW-1:0]        step_ty;
  logic signed [EW-1:0] decision_error;
  logic [DW-1:0]        diam;
  logic                 active;

  logic                 accept;
  logic                 do_start;
  logic                 do_tick;

  logic signed [OW-1:0] x_next;
  logic signed [OW-1:0] y_next;
  logic [SW-1:0]        tx_next;
  logic [SW-1:0]        ty_next;
  logic signed [KW-1:0] e_mid;
  logic signed [KW-1:0] e_next;
  logic                 done_next;
  logic [DW-1:0]        diam_start;

  assign full     = rec_full;
  assign accept   = push && !rec_full;
  assign do_start = accept && (item.op == mcr_pkg::OP_START);
  assign do_tick  = accept && (item.op == mcr_pkg::OP_TICK) && active;

  assign diam_start = {item.radius, 1'b0};

  // Midpoint rule: step y when the error allows, then pull x in if needed.
  always_comb begin
    x_next  = x_offset;
    y_next  = y_offset;
    tx_next = step_tx;
    ty_next = step_ty;
    e_mid   = KW'(decision_error);
    e_next  = e_mid;
    if (decision_error <= 0) begin
      y_next  = y_offset + OW'(1);
      e_mid   = KW'(decision_error) + $signed(KW'(step_ty));
      ty_next = step_ty + SW'(2);
    end
    e_next = e_mid;
    if (e_mid > 0) begin
      x_next  = x_offset - OW'(1);
      tx_next = step_tx + SW'(2);
      e_next  = e_mid + $signed(KW'(tx_next)) - $signed(KW'(diam));
    end
    done_next = (y_next > x_next);
  end

  assign rec_push  = do_tick;
  assign rec.cx    = screen_cx;
  assign rec.cy    = screen_cy;
  assign rec.x_off = x_offset;
  assign rec.y_off = y_offset;
  assign rec.done  = done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_offset_x <= '0;
      screen_offset_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcr_pkg::REG_OFFSET_X: screen_offset_x <= $signed(cfg_data);
        mcr_pkg::REG_OFFSET_Y: screen_offset_y <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_cx      <= '0;
      screen_cy      <= '0;
      x_offset       <= '0;
      y_offset       <= '0;
      step_tx        <= SW'(1);
      step_ty        <= SW'(1);
      decision_error <= '0;
      diam           <= '0;
      active         <= 1'b0;
    end else if (do_start) begin
      screen_cx      <= item.center_x + screen_offset_x;
      screen_cy      <= screen_offset_y - item.center_y;
      x_offset       <= $signed({1'b0, item.radius}) - OW'(1);
      y_offset       <= '0;
      step_tx        <= SW'(1);
      step_ty        <= SW'(1);
      decision_error <= $signed(EW'(1)) - $signed(EW'(diam_start));
      diam           <= diam_start;
      active         <= (item.radius != '0);
    end else if (do_tick) begin
      x_offset       <= x_next;
      y_offset       <= y_next;
      step_tx        <= tx_next;
      step_ty        <= ty_next;
      decision_error <= e_next[EW-1:0];
      active         <= !done_next;
    end
  end

endmodule

// ===== rtl/core/mcr_queue.sv =====
// ----------------------------------------------------------------------------
// mcr_queue
// Short FIFO of step records between the stepper and the point emitter.
// ----------------------------------------------------------------------------
module mcr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  mcr_pkg::step_rec_t wr_data,
  output logic               q_full,
  input  logic               rd_en,
  output logic               rd_valid,
  output mcr_pkg::step_rec_t rd_data
);

  localparam int PW = mcr_pkg::QPTR_WIDTH;
  localparam int NW = $clog2(mcr_pkg::QUEUE_DEPTH + 1);

  mcr_pkg::step_rec_t slots [mcr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full   = (count == NW'(mcr_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/mcr_back.sv =====
// ----------------------------------------------------------------------------
// mcr_back
// Expands each step record into its eight symmetric points, one per cycle while
// the output register is empty or being popped, into that output register.
// ----------------------------------------------------------------------------
module mcr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  mcr_pkg::step_rec_t q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output mcr_pkg::result_t   result
);

  localparam int CW = mcr_pkg::COORD_WIDTH;
  localparam int OW = mcr_pkg::OFFSET_WIDTH;
  localparam int IW = mcr_pkg::POINT_IDX_WIDTH;
  localparam logic [IW-1:0] LAST_IDX = IW'(mcr_pkg::POINTS_PER_STEP - 1);

  mcr_pkg::step_rec_t cur;
  logic               cur_valid;
  logic [IW-1:0]      idx;
  logic               out_valid;

  logic                 out_ready;
  logic                 emit;
  logic                 last_pt;
  logic signed [CW-1:0] x_ext;
  logic signed [CW-1:0] y_ext;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  mcr_pkg::result_t     pt;

  assign out_ready = !out_valid || pop;
  assign emit      = cur_valid && out_ready;
  assign last_pt   = emit && (idx == LAST_IDX);
  assign q_pop     = q_valid && (!cur_valid || last_pt);
  assign empty     = !out_valid;

  assign x_ext = {{(CW-OW){cur.x_off[OW-1]}}, cur.x_off};
  assign y_ext = {{(CW-OW){cur.y_off[OW-1]}}, cur.y_off};

  // Bit 2 swaps the octant, bit 1 mirrors x, bit 0 mirrors y.
  always_comb begin
    dx = idx[2] ? y_ext : x_ext;
    dy = idx[2] ? x_ext : y_ext;
    pt.point_x     = idx[1] ? (cur.cx - dx) : (cur.cx + dx);
    pt.point_y     = idx[0] ? (cur.cy + dy) : (cur.cy - dy);
    pt.step_last   = (idx == LAST_IDX);
    pt.circle_done = cur.done;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (emit) begin
      result <= pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (last_pt) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (emit) begin
        idx <= idx + IW'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/midpoint_circle_rasterizer.sv =====
// Path: a tick's step record is written into the queue, then loaded into the
// emitter's record register, and its first point is registered at the result
// side; its eight points follow one per cycle when pop keeps up. Sustained
// ticks are paced by the point emitter; start and idle-tick items push no
// record. Two step records queue. Reset (synchronous, rst high): offsets 0,
// stepper idle, queue and output empty.
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle stepper with a decoupled eight-point emitter.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mcr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mcr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                push,
  input  mcr_pkg::item_t                      item,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output mcr_pkg::result_t                    result
);

  logic               rec_push;
  logic               rec_full;
  mcr_pkg::step_rec_t rec;
  logic               q_valid;
  logic               q_pop;
  mcr_pkg::step_rec_t q_data;

  mcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .rec_push  (rec_push),
    .rec       (rec),
    .rec_full  (rec_full)
  );

  mcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_push),
    .wr_data  (rec),
    .q_full   (rec_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  mcr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== rtl/core/mcr_checker.sv =====
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks of the midpoint circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mcr_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input mcr_pkg::result_t result
);

  // Reset leaves nothing to read and room for items.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  // A shown result holds until its transaction.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // Points of one step share the final-step flag.
  a_done_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result.circle_done && !result.step_last) |=>
    (empty || result.circle_done))
    else $error("circle_done dropped inside a step");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
